@@ src/hngs_pkg.sv @@
// Shared types and constants of the hashed n-gram class scorer.
// Used by the interfaces, the top level and its checker; depends on nothing.
`default_nettype none
package hngs_pkg;

	localparam int NHEADS    = 6;
	localparam int NCLASS    = 23;
	localparam int SLOT_W    = 5;
	localparam int HEAD_W    = 3;
	localparam int BASE_W    = 17;
	localparam int ADDR_IN_W = 17;
	localparam int WEIGHT_W  = 8;
	localparam int SCORE_W   = 32;
	localparam int COUNT_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int HASH_W    = 32;
	localparam int WIN_W     = 3;

	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = HASH_W / MOD_BITS;
	localparam int MSTEP_W   = $clog2(MOD_STEPS);

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

	localparam logic [WIN_W-1:0] MIN_WIN   = 3'd3;
	localparam logic [WIN_W-1:0] MAX_WIN   = 3'd5;
	localparam logic [WIN_W-1:0] SEEN_MAX  = 3'd5;
	localparam logic [SLOT_W-1:0] LAST_SLOT = 5'd22;

	typedef logic [BASE_W-1:0] base_t;

	localparam base_t BASE_RESET [NHEADS] = '{
		17'd0, 17'd8192, 17'd20480, 17'd40960, 17'd57344, 17'd73728
	};

	localparam logic [2:0] HEAD_CLASSES [NHEADS] = '{
		3'd2, 3'd3, 3'd5, 3'd4, 3'd4, 3'd5
	};

	localparam logic [HEAD_W-1:0] SLOT_HEAD [NCLASS] = '{
		3'd0, 3'd0,
		3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	localparam logic [2:0] SLOT_CLASS [NCLASS] = '{
		3'd0, 3'd1,
		3'd0, 3'd1, 3'd2,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3,
		3'd0, 3'd1, 3'd2, 3'd3,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_ACC,
		ST_NEXT,
		ST_FINISH,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage
`default_nettype wire

@@ src/hngs_if.sv @@
// Valid/ready channel interfaces of the scorer: message and weight requests,
// score results and register writes. Depends on hngs_pkg for field widths.
`default_nettype none
interface hngs_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic [hngs_pkg::ADDR_IN_W-1:0]         weight_addr;
	logic signed [hngs_pkg::WEIGHT_W-1:0]   weight_value;
	logic [7:0]                             text_byte;
	logic                                   end_of_message;

	modport source (output valid, output kind, output weight_addr, output weight_value,
		output text_byte, output end_of_message, input ready);
	modport sink (input valid, input kind, input weight_addr, input weight_value,
		input text_byte, input end_of_message, output ready);
endinterface

interface hngs_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [hngs_pkg::SLOT_W-1:0]            class_slot;
	logic signed [hngs_pkg::SCORE_W-1:0]    score;
	logic [hngs_pkg::COUNT_W-1:0]           ngram_total;
	logic                                   last_of_run;

	modport source (output valid, output class_slot, output score, output ngram_total,
		output last_of_run, input ready);
	modport sink (input valid, input class_slot, input score, input ngram_total,
		input last_of_run, output ready);
endinterface

interface hngs_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [hngs_pkg::CFG_IDX_W-1:0]         index;
	logic [hngs_pkg::BASE_W-1:0]            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/hngs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the weight store and the class sums.
`default_nettype none
module hngs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ src/hashed_ngram_class_scorer.sv @@
// Top level of the hashed character n-gram class scorer.
// Depends on hngs_pkg, the channel interfaces in hngs_if and hngs_ram.
//
// Usage. The items channel carries two kinds of request. A weight request
// (kind 0) writes one signed weight into the weight store. A byte request
// (kind 1) feeds the next byte of a message. For each 3-, 4- and 5-byte
// window ending at that byte an FNV-1a hash is formed one multiply per
// cycle, reduced modulo BUCKETS four bits per cycle, and the 23 weights of
// the chosen bucket are read from the single weight port, one per cycle, and
// added into the class sums held in a small RAM. The windows in use are
// worked through one after another; the next request is taken only once
// they are done. The last byte of a message is followed by 23 score results
// on the scores channel; each sum is cleared as it is read out. A stalled
// receiver holds the result in the output register and the read-out waits;
// the next request is taken while the final score still waits. The cfg
// channel is always ready and sets the six head base offsets. Reset restores
// the base offsets and clears the byte window, count and sums at once; the
// weight store is not cleared and must be written before it is used.
`default_nettype none
module hashed_ngram_class_scorer #(
	parameter int BUCKETS      = 4096,
	parameter int WEIGHT_DEPTH = 94208
) (
	input  logic        clk,
	input  logic        arst_n,
	hngs_in_if.sink     items,
	hngs_out_if.source  scores,
	hngs_cfg_if.sink    cfg
);

	localparam int BW = $clog2(BUCKETS);
	localparam int RW = BW + 1;
	localparam int AW = $clog2(WEIGHT_DEPTH);
	localparam int XW = ((AW > 20) ? AW : 20) + 1;
	localparam int SW = hngs_pkg::SCORE_W;
	localparam int WW = hngs_pkg::WEIGHT_W;

	hngs_pkg::state_t state_q, state_d;

	hngs_pkg::base_t              base_q [hngs_pkg::NHEADS];
	logic [7:0]                   recent_q [4];
	logic [7:0]                   cur_q;
	logic                         eom_q;
	logic [hngs_pkg::WIN_W-1:0]   seen_q;
	logic [hngs_pkg::WIN_W-1:0]   n_q;
	logic [hngs_pkg::WIN_W-1:0]   step_q;
	logic [hngs_pkg::MSTEP_W-1:0] mstep_q;
	logic [hngs_pkg::HASH_W-1:0]  h_q;
	logic [BW-1:0]                rem_q;
	logic [hngs_pkg::SLOT_W-1:0]  slot_q;
	logic [hngs_pkg::COUNT_W-1:0] count_q;
	logic [hngs_pkg::NCLASS-1:0]  sum_vld_q;

	logic                         acc_s1;
	logic [hngs_pkg::SLOT_W-1:0]  slot_s1;
	logic                         oor_s1;
	logic                         svld_s1;

	logic                         out_valid_q;
	logic [hngs_pkg::SLOT_W-1:0]  out_slot_q;
	logic [SW-1:0]                out_score_q;
	logic [hngs_pkg::COUNT_W-1:0] out_total_q;
	logic                         out_last_q;

	logic                         item_acc;
	logic                         byte_acc;
	logic [hngs_pkg::WIN_W-1:0]   seen_inc;
	logic                         hash_last;
	logic                         more_win;
	logic [hngs_pkg::WIN_W-1:0]   hidx;
	logic [7:0]                   hash_byte;
	logic [hngs_pkg::HASH_W-1:0]  hash_next;
	logic [RW-1:0]                mod_r;
	logic [BW-1:0]                rem_next;
	logic [hngs_pkg::HEAD_W-1:0]  head;
	logic [XW-1:0]                addr_x;
	logic                         addr_oor;
	logic [XW-1:0]                wa_x;
	logic                         w_we;
	logic [WW-1:0]                w_rdata;
	logic                         s_we;
	logic [hngs_pkg::SLOT_W-1:0]  s_waddr;
	logic [SW-1:0]                s_wdata;
	logic [SW-1:0]                s_rdata;
	logic [SW-1:0]                w_ext;
	logic [SW-1:0]                acc_sum;
	logic                         emit_go;

	assign items.ready = (state_q == hngs_pkg::ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign item_acc    = items.valid && items.ready;
	assign byte_acc    = item_acc && items.kind;
	assign seen_inc    = (seen_q < hngs_pkg::SEEN_MAX) ? seen_q + 3'd1 : seen_q;
	assign hash_last   = (step_q == n_q - 3'd1);
	assign more_win    = (n_q < hngs_pkg::MAX_WIN) && (seen_q > n_q);
	assign emit_go     = !out_valid_q || scores.ready;

	// Window bytes go in oldest first, the current byte last.
	assign hidx      = n_q - 3'd2 - step_q;
	assign hash_byte = hash_last ? cur_q : recent_q[hidx[1:0]];
	assign hash_next = (h_q ^ {24'd0, hash_byte}) * hngs_pkg::FNV_PRIME;

	always_comb begin
		mod_r = '0;
		mod_r[BW-1:0] = rem_q;
		for (int i = 0; i < hngs_pkg::MOD_BITS; i++) begin
			mod_r = {mod_r[BW-1:0], h_q[hngs_pkg::HASH_W-1-i]};
			if (mod_r >= RW'(BUCKETS)) begin
				mod_r = mod_r - RW'(BUCKETS);
			end
		end
		rem_next = mod_r[BW-1:0];
	end

	assign head     = hngs_pkg::SLOT_HEAD[slot_q];
	assign addr_x   = XW'(base_q[head]) + XW'(rem_q) * XW'(hngs_pkg::HEAD_CLASSES[head])
		+ XW'(hngs_pkg::SLOT_CLASS[slot_q]);
	assign addr_oor = (addr_x >= XW'(WEIGHT_DEPTH));

	assign wa_x = XW'(items.weight_addr);
	assign w_we = item_acc && !items.kind && (wa_x < XW'(WEIGHT_DEPTH));

	hngs_ram #(
		.WIDTH (WW),
		.DEPTH (WEIGHT_DEPTH)
	) u_weights (
		.clk   (clk),
		.we    (w_we),
		.waddr (wa_x[AW-1:0]),
		.wdata (items.weight_value),
		.raddr (addr_x[AW-1:0]),
		.rdata (w_rdata)
	);

	assign w_ext   = oor_s1 ? '0 : {{(SW-WW){w_rdata[WW-1]}}, w_rdata};
	assign acc_sum = (svld_s1 ? s_rdata : '0) + w_ext;
	assign s_we    = acc_s1 || (state_q == hngs_pkg::ST_EMIT_LD);
	assign s_waddr = acc_s1 ? slot_s1 : slot_q;
	assign s_wdata = acc_s1 ? acc_sum : '0;

	hngs_ram #(
		.WIDTH (SW),
		.DEPTH (hngs_pkg::NCLASS)
	) u_sums (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (slot_q),
		.rdata (s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hngs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hngs_pkg::ST_IDLE: begin
				if (byte_acc) begin
					state_d = (seen_inc >= hngs_pkg::MIN_WIN) ? hngs_pkg::ST_HASH
						: hngs_pkg::ST_FINISH;
				end
			end
			hngs_pkg::ST_HASH: begin
				if (hash_last) begin
					state_d = hngs_pkg::ST_MOD;
				end
			end
			hngs_pkg::ST_MOD: begin
				if (mstep_q == hngs_pkg::MSTEP_W'(hngs_pkg::MOD_STEPS - 1)) begin
					state_d = hngs_pkg::ST_ACC;
				end
			end
			hngs_pkg::ST_ACC: begin
				if (slot_q == hngs_pkg::LAST_SLOT) begin
					state_d = hngs_pkg::ST_NEXT;
				end
			end
			hngs_pkg::ST_NEXT: begin
				state_d = more_win ? hngs_pkg::ST_HASH : hngs_pkg::ST_FINISH;
			end
			hngs_pkg::ST_FINISH: begin
				state_d = eom_q ? hngs_pkg::ST_EMIT_RD : hngs_pkg::ST_IDLE;
			end
			hngs_pkg::ST_EMIT_RD: begin
				if (emit_go) begin
					state_d = hngs_pkg::ST_EMIT_LD;
				end
			end
			hngs_pkg::ST_EMIT_LD: begin
				state_d = (slot_q == hngs_pkg::LAST_SLOT) ? hngs_pkg::ST_IDLE
					: hngs_pkg::ST_EMIT_RD;
			end
			default: begin
				state_d = hngs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hngs_pkg::NHEADS; i++) begin
				base_q[i] <= hngs_pkg::BASE_RESET[i];
			end
			for (int i = 0; i < 4; i++) begin
				recent_q[i] <= '0;
			end
			seen_q      <= '0;
			n_q         <= hngs_pkg::MIN_WIN;
			step_q      <= '0;
			mstep_q     <= '0;
			slot_q      <= '0;
			count_q     <= '0;
			sum_vld_q   <= '0;
			acc_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready && (cfg.index < hngs_pkg::CFG_IDX_W'(hngs_pkg::NHEADS))) begin
				base_q[cfg.index] <= cfg.data;
			end
			if (s_we) begin
				sum_vld_q[s_waddr] <= 1'b1;
			end
			acc_s1 <= (state_q == hngs_pkg::ST_ACC);
			if (state_q == hngs_pkg::ST_EMIT_LD) begin
				out_valid_q <= 1'b1;
			end else if (scores.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				hngs_pkg::ST_IDLE: begin
					if (byte_acc) begin
						seen_q <= seen_inc;
						n_q    <= hngs_pkg::MIN_WIN;
						step_q <= '0;
					end
				end
				hngs_pkg::ST_HASH: begin
					step_q <= step_q + 3'd1;
					if (hash_last) begin
						mstep_q <= '0;
						if (count_q != '1) begin
							count_q <= count_q + 24'd1;
						end
					end
				end
				hngs_pkg::ST_MOD: begin
					mstep_q <= mstep_q + 1'b1;
					slot_q  <= '0;
				end
				hngs_pkg::ST_ACC: begin
					slot_q <= (slot_q == hngs_pkg::LAST_SLOT) ? '0 : slot_q + 5'd1;
				end
				hngs_pkg::ST_NEXT: begin
					if (more_win) begin
						n_q    <= n_q + 3'd1;
						step_q <= '0;
					end
				end
				hngs_pkg::ST_FINISH: begin
					if (eom_q) begin
						for (int i = 0; i < 4; i++) begin
							recent_q[i] <= '0;
						end
						seen_q <= '0;
					end else begin
						recent_q[3] <= recent_q[2];
						recent_q[2] <= recent_q[1];
						recent_q[1] <= recent_q[0];
						recent_q[0] <= cur_q;
					end
					slot_q <= '0;
				end
				hngs_pkg::ST_EMIT_LD: begin
					if (slot_q == hngs_pkg::LAST_SLOT) begin
						slot_q  <= '0;
						count_q <= '0;
					end else begin
						slot_q <= slot_q + 5'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= slot_q;
		oor_s1  <= addr_oor;
		svld_s1 <= sum_vld_q[slot_q];
		if (byte_acc) begin
			cur_q <= items.text_byte;
			eom_q <= items.end_of_message;
			h_q   <= hngs_pkg::FNV_BASIS;
		end
		case (state_q)
			hngs_pkg::ST_HASH: begin
				h_q   <= hash_next;
				rem_q <= '0;
			end
			hngs_pkg::ST_MOD: begin
				h_q   <= h_q << hngs_pkg::MOD_BITS;
				rem_q <= rem_next;
			end
			hngs_pkg::ST_NEXT: begin
				h_q <= hngs_pkg::FNV_BASIS;
			end
			hngs_pkg::ST_EMIT_LD: begin
				out_slot_q  <= slot_q;
				out_score_q <= svld_s1 ? s_rdata : '0;
				out_total_q <= count_q;
				out_last_q  <= (slot_q == hngs_pkg::LAST_SLOT);
			end
			default: begin
			end
		endcase
	end

	assign scores.valid       = out_valid_q;
	assign scores.class_slot  = out_slot_q;
	assign scores.score       = out_score_q;
	assign scores.ngram_total = out_total_q;
	assign scores.last_of_run = out_last_q;

endmodule
`default_nettype wire

@@ src/hngs_checker.sv @@
// Port-level checker for the scorer and the bind that attaches it.
// Depends on hngs_pkg and on hashed_ngram_class_scorer being compiled first.
`default_nettype none
module hngs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hngs_pkg::SLOT_W-1:0]   out_slot,
	input logic [hngs_pkg::SCORE_W-1:0]  out_score,
	input logic [hngs_pkg::COUNT_W-1:0]  out_total,
	input logic                          out_last,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	// A result that is not taken must stay as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_score)
			&& $stable(out_total) && $stable(out_last))
		else $error("score result changed while stalled");

	// The final score of a message is exactly the one for the last class.
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_slot == hngs_pkg::LAST_SLOT)))
		else $error("last_of_run does not match the final class slot");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_slot <= hngs_pkg::LAST_SLOT))
		else $error("class slot beyond the last class");

	// No new request is taken while a message's scores are still being read out.
	a_no_input_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("request accepted during score read-out");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write not accepted");

endmodule

bind hashed_ngram_class_scorer hngs_checker u_hngs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (items.ready),
	.out_valid (scores.valid),
	.out_ready (scores.ready),
	.out_slot  (scores.class_slot),
	.out_score (scores.score),
	.out_total (scores.ngram_total),
	.out_last  (scores.last_of_run),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
`default_nettype wire

@@ tb/tb_hashed_ngram_class_scorer.sv @@
// Self-checking testbench of the hashed n-gram class scorer: weight loads, messages
// and base offset writes, with every score predicted and compared in order.
// Depends on hngs_pkg, the channel interfaces in hngs_if and the scorer top level.
module tb_hashed_ngram_class_scorer;
	timeunit 1ns;
	timeprecision 1ps;

	import hngs_pkg::*;

	localparam int BUCKETS        = 4096;
	localparam int WEIGHT_DEPTH   = 94208;
	localparam int MIN_GRAM       = 3;
	localparam int MAX_GRAM       = 5;
	localparam int SEEN_CAP       = 5;
	localparam int SETTLE_CYCLES  = 200;
	localparam int SQUEEZE_LEN    = 3000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_BYTES    = 105;

	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_MULT   = 32'd16777619;
	localparam logic        KIND_WEIGHT = 1'b0;
	localparam logic        KIND_BYTE   = 1'b1;

	localparam int    CLASSES [NHEADS]      = '{2, 3, 5, 4, 4, 5};
	localparam base_t DEFAULT_BASE [NHEADS] = '{17'd0, 17'd8192, 17'd20480, 17'd40960,
		17'd57344, 17'd73728};
	localparam base_t BASE_TOP = base_t'(WEIGHT_DEPTH - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD0_BASE, REG_HEAD1_BASE, REG_HEAD2_BASE, REG_HEAD3_BASE,
		REG_HEAD4_BASE, REG_HEAD5_BASE, REG_SPARE6, REG_SPARE7
	} base_reg_e;

	typedef struct {
		logic                kind;
		logic [16:0]         addr;
		logic signed [7:0]   value;
		logic [7:0]          text;
		logic                eom;
	} request_t;

	typedef struct {
		logic [SLOT_W-1:0]         slot;
		logic signed [31:0]        score;
		logic [COUNT_W-1:0]        total;
		logic                      last;
	} score_t;

	typedef logic [7:0] byte_q_t [$];

	logic clk = 1'b0;
	logic arst_n;

	hngs_in_if  items ();
	hngs_out_if scores ();
	hngs_cfg_if cfg ();

	hashed_ngram_class_scorer #(
		.BUCKETS(BUCKETS),
		.WEIGHT_DEPTH(WEIGHT_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.scores(scores),
		.cfg(cfg)
	);

	always #1 clk = ~clk;

	request_t pending_requests [$];
	score_t   expected_scores [$];
	request_t on_offer;
	score_t   oldest_score;

	base_t             head_base [NHEADS];
	logic [7:0]        recent [4];
	int                seen_bytes;
	logic [COUNT_W-1:0] ngrams;
	logic [31:0]       sums [NCLASS];
	logic signed [7:0] weight_copy [WEIGHT_DEPTH];
	bit                weight_written [WEIGHT_DEPTH];
	logic [7:0]        alphabet [4];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic squeeze_armed = 1'b0;
	int squeeze_cycles = 0;
	logic squeezing;
	int quiet_cycles = 0;

	int failures = 0;
	int requests_queued = 0;
	int bytes_queued = 0;
	int requests_accepted = 0;
	int bytes_accepted = 0;
	int messages_ended = 0;
	int scores_checked = 0;
	int base_settings = 1;

	function automatic int bucket_of(input logic [39:0] win, input int n);
		logic [31:0] h;
		h = FNV_OFFSET;
		for (int k = 0; k < n; k++)
			h = (h ^ {24'd0, win[8*k +: 8]}) * FNV_MULT;
		return int'(h % BUCKETS);
	endfunction

	function automatic int weight_addr_of(input int hd, input int b, input int c);
		return int'(head_base[hd]) + b * CLASSES[hd] + c;
	endfunction

	function automatic void forget_message();
		for (int k = 0; k < 4; k++)
			recent[k] = 8'd0;
		for (int k = 0; k < NCLASS; k++)
			sums[k] = 32'd0;
		seen_bytes = 0;
		ngrams = '0;
	endfunction

	function automatic void absorb_request(input request_t r);
		logic [39:0] win;
		int b;
		int a;
		int slot;
		if (r.kind == KIND_WEIGHT) begin
			if (r.addr < WEIGHT_DEPTH)
				weight_copy[r.addr] = r.value;
			return;
		end
		bytes_accepted++;
		if (seen_bytes < SEEN_CAP)
			seen_bytes++;
		for (int n = MIN_GRAM; n <= MAX_GRAM; n++) begin
			if (seen_bytes >= n) begin
				win = '0;
				for (int k = 0; k < n - 1; k++)
					win[8*k +: 8] = recent[n - 2 - k];
				win[8*(n-1) +: 8] = r.text;
				b = bucket_of(win, n);
				if (ngrams != '1)
					ngrams = ngrams + 1'b1;
				slot = 0;
				for (int hd = 0; hd < NHEADS; hd++) begin
					for (int c = 0; c < CLASSES[hd]; c++) begin
						a = weight_addr_of(hd, b, c);
						if (a < WEIGHT_DEPTH)
							sums[slot] = sums[slot] + {{24{weight_copy[a][7]}}, weight_copy[a]};
						slot++;
					end
				end
			end
		end
		recent[3] = recent[2];
		recent[2] = recent[1];
		recent[1] = recent[0];
		recent[0] = r.text;
		if (r.eom) begin
			for (int k = 0; k < NCLASS; k++)
				expected_scores.push_back('{slot: SLOT_W'(k), score: sums[k], total: ngrams,
					last: (k == NCLASS - 1)});
			messages_ended++;
			forget_message();
		end
	endfunction

	task automatic queue_weight(input int addr, input logic [7:0] value);
		request_t r;
		r.kind = KIND_WEIGHT;
		r.addr = 17'(addr);
		r.value = value;
		r.text = 8'($urandom);
		r.eom = 1'($urandom);
		if (addr < WEIGHT_DEPTH)
			weight_written[addr] = 1'b1;
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	task automatic queue_message(input byte_q_t text);
		request_t r;
		logic [39:0] win;
		int b;
		int a;
		for (int i = 0; i < text.size(); i++) begin
			for (int n = MIN_GRAM; n <= MAX_GRAM; n++) begin
				if (i + 1 >= n) begin
					win = '0;
					for (int k = 0; k < n; k++)
						win[8*k +: 8] = text[i - n + 1 + k];
					b = bucket_of(win, n);
					for (int hd = 0; hd < NHEADS; hd++) begin
						for (int c = 0; c < CLASSES[hd]; c++) begin
							a = weight_addr_of(hd, b, c);
							if (a < WEIGHT_DEPTH && !weight_written[a])
								queue_weight(a, 8'($urandom));
						end
					end
				end
			end
			r.kind = KIND_BYTE;
			r.addr = 17'($urandom);
			r.value = 8'($urandom);
			r.text = text[i];
			r.eom = (i == text.size() - 1);
			pending_requests.push_back(r);
			requests_queued++;
			bytes_queued++;
		end
	endtask

	task automatic queue_random_message();
		byte_q_t text;
		int len;
		int style;
		style = $urandom_range(99);
		len = (style < 5) ? $urandom_range(1, 4) : $urandom_range(1, 11);
		for (int i = 0; i < len; i++) begin
			if (style < 5)
				text.push_back(8'($urandom));
			else if (style < 20)
				text.push_back(alphabet[$urandom_range(3)]);
			else
				text.push_back(alphabet[$urandom_range(1)]);
		end
		queue_message(text);
	endtask

	task automatic write_base(input logic [CFG_IDX_W-1:0] idx, input base_t value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		if (idx <= REG_HEAD5_BASE)
			head_base[idx] = value;
	endtask

	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_requests.size() != 0 || items.valid || expected_scores.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int send_pct, input int recv_pct);
		int first;
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
		for (int k = 0; k < 4; k++)
			alphabet[k] = 8'($urandom);
		first = bytes_queued;
		while (bytes_queued - first < PHASE_BYTES) begin
			if ($urandom_range(99) < 15)
				queue_weight(int'($urandom_range(17'h1FFFF)), 8'($urandom));
			queue_random_message();
		end
		wait_quiet();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
		end else begin
			if (items.valid && items.ready) begin
				absorb_request(on_offer);
				requests_accepted++;
			end
			if (!items.valid || items.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_offer = pending_requests.pop_front();
					items.kind <= on_offer.kind;
					items.weight_addr <= on_offer.addr;
					items.weight_value <= on_offer.value;
					items.text_byte <= on_offer.text;
					items.end_of_message <= on_offer.eom;
					items.valid <= 1'b1;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (squeeze_armed && squeeze_cycles < SQUEEZE_LEN)
			squeeze_cycles <= squeeze_cycles + 1;
	end

	assign squeezing = squeeze_armed && squeeze_cycles < SQUEEZE_LEN;

	always @(posedge clk) begin
		if (!arst_n) begin
			scores.ready <= 1'b0;
		end else begin
			scores.ready <= !squeezing && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && scores.valid && scores.ready) begin
			scores_checked++;
			if (expected_scores.size() == 0) begin
				$error("score with none expected: class_slot %0d, score %0d",
					scores.class_slot, scores.score);
				failures++;
			end else begin
				oldest_score = expected_scores.pop_front();
				if (scores.class_slot !== oldest_score.slot) begin
					$error("class_slot: expected %0d, got %0d", oldest_score.slot, scores.class_slot);
					failures++;
				end
				if (scores.score !== oldest_score.score) begin
					$error("score: expected %0d, got %0d", oldest_score.score, scores.score);
					failures++;
				end
				if (scores.ngram_total !== oldest_score.total) begin
					$error("ngram_total: expected %0d, got %0d", oldest_score.total,
						scores.ngram_total);
					failures++;
				end
				if (scores.last_of_run !== oldest_score.last) begin
					$error("last_of_run: expected %0d, got %0d", oldest_score.last,
						scores.last_of_run);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (items.valid && items.ready) || (scores.valid && scores.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_hashed_ngram_class_scorer: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		byte_q_t text;
		arst_n = 1'b0;
		items.valid = 1'b0;
		items.kind = KIND_BYTE;
		items.weight_addr = '0;
		items.weight_value = '0;
		items.text_byte = '0;
		items.end_of_message = 1'b0;
		scores.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		for (int hd = 0; hd < NHEADS; hd++)
			head_base[hd] = DEFAULT_BASE[hd];
		forget_message();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme weights and addresses, including writes past the end of the store.
		queue_weight(0, 8'h80);
		queue_weight(WEIGHT_DEPTH - 1, 8'h7F);
		queue_weight(17'h1FFFF, 8'h55);
		queue_weight(WEIGHT_DEPTH, 8'hFF);
		// Messages too short for any n-gram, then the smallest and saturating windows.
		text = '{8'h00};
		queue_message(text);
		text = '{8'hFF, 8'h00};
		queue_message(text);
		text = '{8'h00, 8'h00, 8'h00};
		queue_message(text);
		text = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		queue_message(text);
		text = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		queue_message(text);
		wait_quiet();
		run_random(0, 0);

		for (int hd = 0; hd < NHEADS; hd++)
			write_base(CFG_IDX_W'(REG_HEAD0_BASE + hd), base_t'($urandom_range(WEIGHT_DEPTH - 1)));
		base_settings++;
		run_random(65, 0);

		// Bases at the top of the store make almost all reads of heads 0, 3 and 5 fall off the end.
		write_base(REG_HEAD0_BASE, BASE_TOP);
		write_base(REG_HEAD1_BASE, '0);
		write_base(REG_HEAD2_BASE, '0);
		write_base(REG_HEAD3_BASE, BASE_TOP);
		write_base(REG_HEAD4_BASE, base_t'($urandom_range(WEIGHT_DEPTH - 1)));
		write_base(REG_HEAD5_BASE, BASE_TOP);
		base_settings++;
		squeeze_armed <= 1'b1;
		run_random(0, 65);

		for (int hd = 0; hd < NHEADS; hd++)
			write_base(CFG_IDX_W'(REG_HEAD0_BASE + hd), '0);
		write_base(REG_SPARE6, base_t'($urandom));
		write_base(REG_SPARE7, base_t'($urandom));
		base_settings++;
		run_random(26, 26);

		for (int hd = 0; hd < NHEADS; hd++)
			write_base(CFG_IDX_W'(REG_HEAD0_BASE + hd), DEFAULT_BASE[hd]);
		base_settings++;
		run_random(0, 0);

		if (expected_scores.size() != 0) begin
			$error("%0d scores never arrived", expected_scores.size());
			failures++;
		end
		$display("Run covered %0d requests, %0d of them message bytes, in %0d messages.",
			requests_accepted, bytes_accepted, messages_ended);
		$display("Checked %0d scores under %0d base offset settings.", scores_checked,
			base_settings);
		if (failures == 0) begin
			$display("tb_hashed_ngram_class_scorer: PASS");
		end else begin
			$display("tb_hashed_ngram_class_scorer: FAIL");
		end
		$finish;
	end

endmodule
